FILE: rtl/pbwe_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the banked pixel write engine
// no dependencies
package pbwe_pkg;

  // byte size of one bank window, a power of two
  localparam int unsigned BankBytes = 65536;
  localparam int unsigned BankShift = $clog2(BankBytes);

  // y < 4096 and pitch < 16384 keep the byte address below 2**26
  localparam int unsigned AddrW = 26;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitsPerPixel = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLinePitch    = 3'd3;

  localparam logic [15:0] NoBank = 16'hFFFF;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [5:0]  bits_per_pixel;
    logic [13:0] line_pitch;
  } pbwe_cfg_t;

  // one classified pixel waiting for the back end
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [31:0]      raw;
    logic [2:0]       nbytes;
  } pbwe_entry_t;

  // one byte write
  typedef struct packed {
    logic        select_bank;
    logic [15:0] bank_number;
    logic [15:0] window_offset;
    logic [7:0]  byte_value;
    logic        last_byte;
  } pbwe_byte_t;

endpackage

FILE: rtl/banked_pixel_write_engine_unit.sv
`timescale 1ns / 1ps
// top level of the banked pixel write engine: configuration registers, front end,
// pixel queue and back end; depends on pbwe_pkg, pbwe_front, pbwe_queue, pbwe_back
//
// A pixel is taken every cycle that full is low; on-screen pixels are classified
// and put into a four-entry queue, off-screen pixels and zero depth are dropped.
// The back end sends one byte write per cycle while its output register is free
// or popped; that byte sequencer sets the rate. A pixel has one to four bytes (four
// at 32 bpp). A result waits in an output register until popped. Bytes come
// lowest first; select_bank is set when the bank differs from the last one sent,
// and a write to a configuration register forgets the bank. Configuration writes
// are always ready and are meant to come only while the engine is idle.
module banked_pixel_write_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbwe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbwe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [15:0]                   pixel_x_i,
  input  logic [15:0]                   pixel_y_i,
  input  logic [31:0]                   pixel_color_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          select_bank_o,
  output logic [15:0]                   bank_number_o,
  output logic [15:0]                   window_offset_o,
  output logic [7:0]                    byte_value_o,
  output logic                          last_byte_o
);
  import pbwe_pkg::*;

  pbwe_cfg_t   cfg_q, cfg_d;
  logic        cfg_we, bank_clr;
  logic        keep, q_full, q_avail, q_rd;
  pbwe_entry_t front_entry, q_head;
  pbwe_byte_t  out_byte;

  always_comb begin
    cfg_ready_o = 1'b1;
    cfg_we      = cfg_valid_i;
    cfg_d       = cfg_q;
    bank_clr    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        RegScreenWidth: begin
          cfg_d.screen_width = cfg_data_i[11:0];
          bank_clr = 1'b1;
        end
        RegScreenHeight: begin
          cfg_d.screen_height = cfg_data_i[11:0];
          bank_clr = 1'b1;
        end
        RegBitsPerPixel: begin
          cfg_d.bits_per_pixel = cfg_data_i[5:0];
          bank_clr = 1'b1;
        end
        RegLinePitch: begin
          cfg_d.line_pitch = cfg_data_i[13:0];
          bank_clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width   <= 12'd1024;
      cfg_q.screen_height  <= 12'd768;
      cfg_q.bits_per_pixel <= 6'd32;
      cfg_q.line_pitch     <= 14'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pbwe_front u_front (
    .cfg_i         (cfg_q),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .pixel_color_i (pixel_color_i),
    .keep_o        (keep),
    .entry_o       (front_entry)
  );

  pbwe_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push && keep),
    .wr_data_i (front_entry),
    .rd_i      (q_rd),
    .rd_data_o (q_head),
    .full_o    (q_full),
    .avail_o   (q_avail)
  );

  pbwe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bank_clr_i (bank_clr),
    .q_avail_i  (q_avail),
    .q_data_i   (q_head),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_byte)
  );

  assign full            = q_full;
  assign select_bank_o   = out_byte.select_bank;
  assign bank_number_o   = out_byte.bank_number;
  assign window_offset_o = out_byte.window_offset;
  assign byte_value_o    = out_byte.byte_value;
  assign last_byte_o     = out_byte.last_byte;

endmodule

FILE: rtl/pbwe_front.sv
`timescale 1ns / 1ps
// front end: bounds check, byte count, color packing and byte address
// depends on pbwe_pkg
module pbwe_front (
  input  pbwe_pkg::pbwe_cfg_t   cfg_i,
  input  logic [15:0]           pixel_x_i,
  input  logic [15:0]           pixel_y_i,
  input  logic [31:0]           pixel_color_i,
  output logic                  keep_o,
  output pbwe_pkg::pbwe_entry_t entry_o
);
  import pbwe_pkg::*;

  logic                 on_screen;
  logic [6:0]           depth_sum;
  logic [3:0]           nb_raw;
  logic [2:0]           nbytes;
  logic [AddrW-1:0]     row_addr;
  logic [14:0]          col_addr;
  logic [31:0]          raw;

  always_comb begin
    on_screen = !pixel_x_i[15] && !pixel_y_i[15]
                && (pixel_x_i < {4'd0, cfg_i.screen_width})
                && (pixel_y_i < {4'd0, cfg_i.screen_height});

    // (bits + 7) / 8, saturated at four bytes
    depth_sum = {1'b0, cfg_i.bits_per_pixel} + 7'd7;
    nb_raw    = depth_sum[6:3];
    nbytes    = (nb_raw > 4'd4) ? 3'd4 : nb_raw[2:0];

    row_addr = AddrW'(pixel_y_i[11:0]) * AddrW'(cfg_i.line_pitch);
    col_addr = 15'(pixel_x_i[11:0]) * 15'(nbytes);

    unique case (cfg_i.bits_per_pixel)
      6'd24:   raw = {8'd0, pixel_color_i[23:0]};
      6'd16:   raw = {16'd0, pixel_color_i[23:19], pixel_color_i[15:10],
                      pixel_color_i[7:3]};
      default: raw = pixel_color_i;
    endcase

    keep_o         = on_screen && (nbytes != 3'd0);
    entry_o.addr   = row_addr + AddrW'(col_addr);
    entry_o.raw    = raw;
    entry_o.nbytes = nbytes;
  end

endmodule

FILE: rtl/pbwe_queue.sv
`timescale 1ns / 1ps
// short queue of classified pixels between front and back end
// depends on pbwe_pkg
module pbwe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  pbwe_pkg::pbwe_entry_t wr_data_i,
  input  logic                  rd_i,
  output pbwe_pkg::pbwe_entry_t rd_data_o,
  output logic                  full_o,
  output logic                  avail_o
);
  import pbwe_pkg::*;

  pbwe_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             do_wr, do_rd;

  always_comb begin
    full_o    = (count_q == (QPtrW+1)'(QDepth));
    avail_o   = (count_q != '0);
    rd_data_o = mem_q[rd_ptr_q];
    do_wr     = wr_i && !full_o;
    do_rd     = rd_i && avail_o;
    wr_ptr_d  = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d  = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d   = count_q + (QPtrW+1)'(do_wr) - (QPtrW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/pbwe_back.sv
`timescale 1ns / 1ps
// back end: splits one pixel into byte writes, tracks the selected bank
// depends on pbwe_pkg
module pbwe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  bank_clr_i,
  input  logic                  q_avail_i,
  input  pbwe_pkg::pbwe_entry_t q_data_i,
  output logic                  q_rd_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output pbwe_pkg::pbwe_byte_t  out_o
);
  import pbwe_pkg::*;

  logic             cur_valid_q, cur_valid_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [31:0]      raw_q, raw_d;
  logic [2:0]       rem_q, rem_d;
  logic [15:0]      cached_q, cached_d;
  logic             out_valid_q, out_valid_d;
  pbwe_byte_t       out_q, out_d;
  logic             out_free, emit, last;
  logic [15:0]      bank;

  always_comb begin
    out_free = !out_valid_q || pop_i;
    emit     = cur_valid_q && out_free;
    last     = (rem_q == 3'd1);
    bank     = 16'(addr_q[AddrW-1:BankShift]);
    q_rd_o   = !cur_valid_q || (emit && last);

    out_d.select_bank   = (bank != cached_q);
    out_d.bank_number   = bank;
    out_d.window_offset = 16'(addr_q[BankShift-1:0]);
    out_d.byte_value    = raw_q[7:0];
    out_d.last_byte     = last;

    out_valid_d = emit ? 1'b1 : (out_free ? 1'b0 : out_valid_q);
    cached_d    = emit ? bank : cached_q;
    if (bank_clr_i) begin
      cached_d = NoBank;
    end

    cur_valid_d = cur_valid_q;
    addr_d      = addr_q;
    raw_d       = raw_q;
    rem_d       = rem_q;
    if (q_rd_o) begin
      // load the next pixel, also right behind the last byte of this one
      cur_valid_d = q_avail_i;
      addr_d      = q_data_i.addr;
      raw_d       = q_data_i.raw;
      rem_d       = q_data_i.nbytes;
    end else if (emit) begin
      addr_d = addr_q + 1'b1;
      raw_d  = {8'd0, raw_q[31:8]};
      rem_d  = rem_q - 3'd1;
    end

    empty_o = !out_valid_q;
    out_o   = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cached_q    <= NoBank;
      rem_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      cached_q    <= cached_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    raw_q  <= raw_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/pbwe_checker.sv
`timescale 1ns / 1ps
// port-level checks of the banked pixel write engine and their bind
// depends on pbwe_pkg and banked_pixel_write_engine_unit
module pbwe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [pbwe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [pbwe_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                          push,
  input logic                          full,
  input logic [15:0]                   pixel_x_i,
  input logic [15:0]                   pixel_y_i,
  input logic [31:0]                   pixel_color_i,
  input logic                          empty,
  input logic                          pop,
  input logic                          select_bank_o,
  input logic [15:0]                   bank_number_o,
  input logic [15:0]                   window_offset_o,
  input logic [7:0]                    byte_value_o,
  input logic                          last_byte_o
);
  import pbwe_pkg::*;

  // a waiting item holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(bank_number_o) && $stable(window_offset_o)
                          && $stable(byte_value_o) && $stable(last_byte_o)))
    else $error("result changed while stalled");

  // the bytes of one pixel follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=> !empty)
    else $error("gap inside a pixel");

  // the next byte of a pixel is at the next address
  a_next_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=>
      ((window_offset_o == $past(window_offset_o) + 16'd1
        && bank_number_o == $past(bank_number_o))
       || (window_offset_o == 16'd0
           && bank_number_o == $past(bank_number_o) + 16'd1)))
    else $error("byte address not consecutive");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind banked_pixel_write_engine_unit pbwe_checker u_pbwe_checker (.*);
